>>> sv/circular_deque_macros.svh
// assertion macros for the circular deque checker
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// same-cycle implication under active-low reset
`define CDQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("circular_deque check failed");

// next-cycle implication under active-low reset
`define CDQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("circular_deque check failed");

`endif

>>> sv/cdq_pkg.sv
// opcode and error codes shared by the circular deque files
package cdq_pkg;

    localparam int OP_W  = 3;
    localparam int ERR_W = 2;
    localparam int IO_W  = 32;

    localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK      = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;

    typedef logic [IO_W-1:0] io_word_t;

endpackage

>>> sv/cdq_ram.sv
// single-port-write, single-port-read ring storage with registered read
module cdq_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/circular_deque.sv
// circular deque: ring-buffer double-ended queue with cached front and rear words
// results: insert, peek and error words are registered directly; a delete that
// leaves entries first fetches the new end word through the storage read port
// throughput: one word per cycle if m_ready allows; a fetching delete stalls s_ready
// reset: indices to 0, deque empty, no result pending; storage is not cleared
module circular_deque import cdq_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [OP_W-1:0]  s_opcode,
    input  io_word_t         s_data_in,
    output logic             m_valid,
    input  logic             m_ready,
    output io_word_t         m_front_value,
    output io_word_t         m_rear_value,
    output logic             m_is_empty,
    output logic             m_is_full,
    output logic [ERR_W-1:0] m_error_code
);

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int STORE_W = (DATA_WIDTH < IO_W) ? DATA_WIDTH : IO_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    logic               state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic               empty_reg, empty_next;
    logic               m_valid_reg, m_valid_next;
    logic               sel_front_reg, sel_front_next;
    logic [STORE_W-1:0] front_reg, front_next;
    logic [STORE_W-1:0] rear_reg, rear_next;
    logic [ERR_W-1:0]   err_reg, err_next;

    logic               accept;
    logic               full_w;
    logic               go_read;
    logic [STORE_W-1:0] word_in;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [STORE_W-1:0] rd_data;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign full_w  = !empty_reg && (idx_inc(tail_reg) == head_reg);
    assign word_in = s_data_in[STORE_W-1:0];

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        m_valid_next   = m_valid_reg;
        sel_front_next = sel_front_reg;
        front_next     = front_reg;
        rear_next      = rear_reg;
        err_next       = err_reg;
        go_read        = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        rd_addr        = idx_inc(head_reg);

        if (state_reg == ST_IDLE && accept) begin
            err_next = ERR_NONE;
            case (s_opcode)
                OP_INS_REAR, OP_INS_FRONT: begin
                    if (full_w) begin
                        err_next = ERR_OVERFLOW;
                    end else if (empty_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        front_next = word_in;
                        rear_next  = word_in;
                    end else if (s_opcode == OP_INS_REAR) begin
                        tail_next = idx_inc(tail_reg);
                        wr_en     = 1'b1;
                        wr_addr   = idx_inc(tail_reg);
                        rear_next = word_in;
                    end else begin
                        head_next  = idx_dec(head_reg);
                        wr_en      = 1'b1;
                        wr_addr    = idx_dec(head_reg);
                        front_next = word_in;
                    end
                end
                OP_DEL_FRONT, OP_DEL_REAR: begin
                    if (empty_reg) begin
                        err_next = ERR_UNDERFLOW;
                    end else if (head_reg == tail_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end else if (s_opcode == OP_DEL_FRONT) begin
                        head_next      = idx_inc(head_reg);
                        rd_addr        = idx_inc(head_reg);
                        sel_front_next = 1'b1;
                        go_read        = 1'b1;
                    end else begin
                        tail_next      = idx_dec(tail_reg);
                        rd_addr        = idx_dec(tail_reg);
                        sel_front_next = 1'b0;
                        go_read        = 1'b1;
                    end
                end
                OP_PEEK: begin
                    if (empty_reg) begin
                        err_next = ERR_UNDERFLOW;
                    end
                end
                default: begin
                end
            endcase
            if (go_read) begin
                state_next   = ST_READ;
                m_valid_next = 1'b0;
            end else begin
                m_valid_next = 1'b1;
            end
        end else if (state_reg == ST_READ) begin
            if (sel_front_reg) begin
                front_next = rd_data;
            end else begin
                rear_next = rd_data;
            end
            state_next   = ST_IDLE;
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            empty_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            empty_reg   <= empty_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_front_reg <= sel_front_next;
        front_reg     <= front_next;
        rear_reg      <= rear_next;
        err_reg       <= err_next;
    end

    cdq_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (STORE_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (word_in),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // front and rear read as zero while empty
    assign m_valid       = m_valid_reg;
    assign m_front_value = empty_reg ? '0 : IO_W'(front_reg);
    assign m_rear_value  = empty_reg ? '0 : IO_W'(rear_reg);
    assign m_is_empty    = empty_reg;
    assign m_is_full     = full_w;
    assign m_error_code  = err_reg;

endmodule

>>> sv/cdq_checker.sv
// port-level checker for the circular deque and its bind
`include "circular_deque_macros.svh"

module cdq_checker import cdq_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [OP_W-1:0]  s_opcode,
    input io_word_t         s_data_in,
    input logic             m_valid,
    input logic             m_ready,
    input io_word_t         m_front_value,
    input io_word_t         m_rear_value,
    input logic             m_is_empty,
    input logic             m_is_full,
    input logic [ERR_W-1:0] m_error_code
);

    logic                           empty_word;
    logic                           empty_ok;
    logic                           ovf_word;
    logic                           unf_word;
    logic                           out_stall;
    logic                           in_stall;
    logic [2*IO_W+ERR_W-1:0]        out_word;
    logic [OP_W+IO_W-1:0]           in_word;

    assign empty_word = m_valid && m_is_empty;
    assign empty_ok   = (m_front_value == '0) && (m_rear_value == '0) && !m_is_full;
    assign ovf_word   = m_valid && (m_error_code == ERR_OVERFLOW);
    assign unf_word   = m_valid && (m_error_code == ERR_UNDERFLOW);
    assign out_stall  = m_valid && !m_ready;
    assign in_stall   = s_valid && !s_ready;
    assign out_word   = {m_front_value, m_rear_value, m_error_code};
    assign in_word    = {s_opcode, s_data_in};

    // empty word shows zero ends and is never full
    `CDQ_ASSERT_NOW(a_empty_word, aclk, aresetn, empty_word, empty_ok)

    // overflow only reported against a full deque
    `CDQ_ASSERT_NOW(a_overflow_full, aclk, aresetn, ovf_word, m_is_full)

    // underflow only reported against an empty deque
    `CDQ_ASSERT_NOW(a_underflow_empty, aclk, aresetn, unf_word, m_is_empty)

    // stalled result word holds
    `CDQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(out_word))

    // stalled input word holds
    `CDQ_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_stall, s_valid && $stable(in_word))

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_opcode      (s_opcode),
    .s_data_in     (s_data_in),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_front_value (m_front_value),
    .m_rear_value  (m_rear_value),
    .m_is_empty    (m_is_empty),
    .m_is_full     (m_is_full),
    .m_error_code  (m_error_code)
);
